### hdl/dfr_pkg.sv
// Shared types, constants and the Modbus CRC16 byte update for the deframer.
// No dependencies.
package dfr_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'h5B;
  localparam logic [7:0] TAIL_BYTE = 8'hA5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADLEN  = 2'd1;
  localparam logic [1:0] ST_BADTAIL = 2'd2;
  localparam logic [1:0] ST_BADCRC  = 2'd3;

  localparam int TOTAL_W = 11;

  typedef struct packed {
    logic [7:0]         body_byte;
    logic               frame_end;
    logic [1:0]         frame_status;
    logic [TOTAL_W-1:0] frame_total;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/dfr_in_reg.sv
// Input register for received bytes.
// Uses no package items.
module dfr_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       vld_r,
  output logic [7:0] byte_r
);

  assign in_ready = !vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

### hdl/dfr_parse.sv
// Frame parser: phase sequencer, length and offset tracking, CRC check.
// Depends on dfr_pkg.
module dfr_parse #(
  parameter int MAX_FRAME = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic [7:0]    byte_i,
  output logic          emit,
  output dfr_pkg::res_t res
);

  localparam int OFF_W = $clog2(MAX_FRAME);

  localparam logic [2:0] PH_HUNT1 = 3'd0;
  localparam logic [2:0] PH_HUNT2 = 3'd1;
  localparam logic [2:0] PH_LENLO = 3'd2;
  localparam logic [2:0] PH_LENHI = 3'd3;
  localparam logic [2:0] PH_BODY  = 3'd4;
  localparam logic [2:0] PH_CRCLO = 3'd5;
  localparam logic [2:0] PH_CRCHI = 3'd6;
  localparam logic [2:0] PH_TAIL  = 3'd7;

  logic [2:0]       phase_r, phase_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      crc_rx_r, crc_rx_nxt;

  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [16:0] len_ext, len_p2, len_p4, full_p4, off_p1;

  assign crc_upd  = dfr_pkg::crc_feed(crc_r, byte_i);
  assign len_full = {byte_i, len_r[7:0]};
  assign len_ext  = {1'b0, len_r};
  assign len_p2   = len_ext + 17'd2;
  assign len_p4   = len_ext + 17'd4;
  assign full_p4  = {1'b0, len_full} + 17'd4;
  assign off_p1   = 17'(off_r) + 17'd1;

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    off_nxt    = off_r;
    crc_nxt    = crc_r;
    crc_rx_nxt = crc_rx_r;
    emit       = 1'b0;
    res        = '0;
    unique case (phase_r)
      PH_HUNT1: begin
        if (byte_i == dfr_pkg::HDR_BYTE) begin
          phase_nxt = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (byte_i == dfr_pkg::HDR_BYTE) begin
          phase_nxt = PH_LENLO;
          crc_nxt   = dfr_pkg::CRC_INIT;
          off_nxt   = OFF_W'(2);
        end else begin
          phase_nxt = PH_HUNT1;
        end
      end
      PH_LENLO: begin
        len_nxt   = {8'h00, byte_i};
        crc_nxt   = crc_upd;
        off_nxt   = OFF_W'(3);
        phase_nxt = PH_LENHI;
      end
      PH_LENHI: begin
        len_nxt = len_full;
        crc_nxt = crc_upd;
        off_nxt = OFF_W'(4);
        if (len_full < 16'd8 || full_p4 > 17'(MAX_FRAME)) begin
          emit             = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_status = dfr_pkg::ST_BADLEN;
          res.frame_total  = dfr_pkg::TOTAL_W'(4);
          phase_nxt        = PH_HUNT1;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        crc_nxt       = crc_upd;
        emit          = 1'b1;
        res.body_byte = byte_i;
        off_nxt       = off_p1[OFF_W-1:0];
        if (off_p1 >= len_ext) begin
          phase_nxt = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        crc_rx_nxt = {8'h00, byte_i};
        off_nxt    = off_p1[OFF_W-1:0];
        phase_nxt  = PH_CRCHI;
      end
      PH_CRCHI: begin
        crc_rx_nxt = {byte_i, crc_rx_r[7:0]};
        off_nxt    = off_p1[OFF_W-1:0];
        phase_nxt  = PH_TAIL;
      end
      PH_TAIL: begin
        if (byte_i != dfr_pkg::TAIL_BYTE) begin
          emit             = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_status = dfr_pkg::ST_BADTAIL;
          res.frame_total  = off_p1[dfr_pkg::TOTAL_W-1:0];
          phase_nxt        = PH_HUNT1;
        end else if (17'(off_r) == len_p2) begin
          off_nxt = off_p1[OFF_W-1:0];
        end else begin
          emit             = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_status = (crc_rx_r != crc_r) ? dfr_pkg::ST_BADCRC : dfr_pkg::ST_OK;
          res.frame_total  = len_p4[dfr_pkg::TOTAL_W-1:0];
          phase_nxt        = PH_HUNT1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT1;
      len_r    <= '0;
      off_r    <= '0;
      crc_r    <= dfr_pkg::CRC_INIT;
      crc_rx_r <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      off_r    <= off_nxt;
      crc_r    <= crc_nxt;
      crc_rx_r <= crc_rx_nxt;
    end
  end

  a_close_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit && res.frame_end) |=> (phase_r == PH_HUNT1))
    else $error("closing item did not return to header hunt");

  a_body_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (17'(off_r) < len_ext && len_r >= 16'd8))
    else $error("body offset outside frame length");

  a_body_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (phase_r == PH_BODY)) |-> (!res.frame_end && res.frame_total == '0))
    else $error("body item carries closing fields");

endmodule

### hdl/dfr_out_reg.sv
// Result register for body and closing items.
// Depends on dfr_pkg for the result type.
module dfr_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          emit,
  input  dfr_pkg::res_t res,
  input  logic          out_ready,
  output logic          out_valid,
  output dfr_pkg::res_t res_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= res;
    end
  end

endmodule

### hdl/response_frame_deframer_crc16.sv
// Top level of the response frame deframer with Modbus CRC16 check.
// Depends on dfr_pkg, dfr_in_reg, dfr_parse, dfr_out_reg.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | in_rx_byte
//   out_    | output    | out_valid / out_ready  | out_body_byte, out_frame_end,
//           |           |                        | out_frame_status, out_frame_total
//
// One byte per cycle sustained unless the result register stalls; an accepted
// byte is held in the input register, then its result in the result register.
// Synchronous active-low reset returns the parser to header hunt.
// A stalled result register holds the parser and the input register; in_ready
// stays high while the input register can drain in the same cycle.
module response_frame_deframer_crc16 #(
  parameter int MAX_FRAME = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_body_byte,
  output logic        out_frame_end,
  output logic [1:0]  out_frame_status,
  output logic [10:0] out_frame_total
);

  logic          vld_r;
  logic [7:0]    byte_r;
  logic          advance;
  logic          emit;
  dfr_pkg::res_t res;
  dfr_pkg::res_t res_r;

  assign advance = vld_r && (!out_valid || out_ready);

  dfr_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .vld_r      (vld_r),
    .byte_r     (byte_r)
  );

  dfr_parse #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_i  (byte_r),
    .emit    (emit),
    .res     (res)
  );

  dfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .emit      (emit),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_r     (res_r)
  );

  assign out_body_byte    = res_r.body_byte;
  assign out_frame_end    = res_r.frame_end;
  assign out_frame_status = res_r.frame_status;
  assign out_frame_total  = res_r.frame_total;

endmodule
